>>> sv/lsdp_pkg.sv
// Shared types and fixed widths for the LRU stack distance profiler.
// No dependencies; imported by lsdp_cell and lru_stack_distance_profiler_core.
`default_nettype none

package lsdp_pkg;

  localparam int ADDR_W      = 58;  // cache-line address width
  localparam int IN_TDATA_W  = 64;  // address padded to whole bytes
  localparam int DIST_W      = 7;   // stack_distance field
  localparam int OUT_IDX_W   = 32;  // earlier_index / reuse_distance fields
  localparam int OUT_TDATA_W = 72;  // 7 + 32 + 32 = 71, padded to whole bytes

  // Lookup wavefront handed from one cell to the next
  typedef struct packed {
    logic              active;       // wavefront sits at this cell this cycle
    logic [ADDR_W-1:0] addr;         // address being looked up
    logic              carry_valid;  // entry pushed down from above
    logic [ADDR_W-1:0] carry_tag;
  } wave_t;

  // Per-cell outcome, meaningful only in the cycle the wavefront is there
  typedef struct packed {
    logic done;  // lookup ends at this cell
    logic hit;   // ended on a matching entry
  } cell_status_t;

endpackage : lsdp_pkg

`default_nettype wire

>>> sv/lsdp_cell.sv
// One entry of the LRU stack: tag, valid bit and last access index.
// Swaps its entry with the wavefront's carried entry and passes the old one down.
// Depends on lsdp_pkg.
`default_nettype none

module lsdp_cell
  import lsdp_pkg::*;
#(
  parameter int INDEX_WIDTH = 32,
  parameter bit IS_LAST     = 1'b0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire wave_t                  wave_in,
  input  wire logic [INDEX_WIDTH-1:0] idx_in,
  output      wave_t                  wave_out,
  output      logic [INDEX_WIDTH-1:0] idx_out,
  output      cell_status_t           status,
  output      logic [INDEX_WIDTH-1:0] earlier_idx
);

  logic                   valid_r;
  logic [ADDR_W-1:0]      tag_r;
  logic [INDEX_WIDTH-1:0] idx_r;
  wave_t                  wave_r;
  wave_t                  wave_nxt;
  logic [INDEX_WIDTH-1:0] idx_out_r;
  logic                   match;

  assign match = valid_r && (tag_r == wave_in.addr);

  // keep walking only past a valid, non-matching entry that is not the bottom
  always_comb begin
    wave_nxt             = wave_in;
    wave_nxt.active      = wave_in.active && !match && valid_r && !IS_LAST;
    wave_nxt.carry_valid = valid_r;
    wave_nxt.carry_tag   = tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      wave_r.active <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
      if (wave_in.active) begin
        valid_r <= wave_in.carry_valid;
      end
    end
  end

  // entry payload: take the carried entry whenever the wavefront passes
  always_ff @(posedge clk) begin
    if (wave_in.active) begin
      tag_r     <= wave_in.carry_tag;
      idx_r     <= idx_in;
      idx_out_r <= idx_r;
    end
  end

  assign wave_out    = wave_r;
  assign idx_out     = idx_out_r;
  assign status.done = wave_in.active && (match || !valid_r || IS_LAST);
  assign status.hit  = wave_in.active && match;
  assign earlier_idx = idx_r;

endmodule : lsdp_cell

`default_nettype wire

>>> sv/lru_stack_distance_profiler_core.sv
// LRU stack distance profiler, top level: input/output beats, access counter,
// lookup sequencing and result collection over a chain of lsdp_cell entries.
// Depends on lsdp_pkg and lsdp_cell.
//
//  Channel | Ports                       | Payload
//  --------+-----------------------------+---------------------------------------
//  in      | in_tvalid/in_tready/in_tdata | line_address
//  out     | out_tvalid/out_tready/       | tuser: hit; tdata: stack_distance,
//          | out_tdata/out_tuser          | earlier_index, reuse_distance
//
// A beat enters cell 0 at its accept edge; the lookup wavefront then moves one
// cell per cycle down the chain until it meets the matching entry, an empty
// entry, or the bottom. Reset (rst_n low, synchronous) empties the stack and
// zeroes the access counter. A stalled result is parked in a hold register;
// no new beat is taken until it moves to the output register.
`default_nettype none

module lru_stack_distance_profiler_core
  import lsdp_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int INDEX_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: [57:0] line_address, [63:58] zero
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [6:0] stack_distance, [38:7] earlier_index,
  //            [70:39] reuse_distance, [71] zero
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] hit
  output      logic                   out_tuser
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [INDEX_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [INDEX_WIDTH-1:0] now_r, now_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [DIST_W-1:0]      out_dist_r, out_dist_nxt;
  logic [OUT_IDX_W-1:0]   out_earlier_r, out_earlier_nxt;
  logic [OUT_IDX_W-1:0]   out_reuse_r, out_reuse_nxt;

  logic                   hold_hit_r;
  logic [DIST_W-1:0]      hold_dist_r;
  logic [OUT_IDX_W-1:0]   hold_earlier_r;
  logic [OUT_IDX_W-1:0]   hold_reuse_r;

  wave_t                  chain_wave [DEPTH+1];
  logic [INDEX_WIDTH-1:0] chain_idx  [DEPTH+1];
  cell_status_t           cell_status [DEPTH];
  logic [INDEX_WIDTH-1:0] cell_earlier [DEPTH];

  logic                   accept;
  logic                   res_done;
  logic                   res_hit;
  logic [INDEX_WIDTH-1:0] res_earlier;
  logic [PW-1:0]          cur_pos;
  logic [INDEX_WIDTH-1:0] cur_now;
  logic [INDEX_WIDTH-1:0] reuse_full;
  logic [63:0]            dist_ext;
  logic [63:0]            earlier_ext;
  logic [63:0]            reuse_ext;
  logic [DIST_W-1:0]      res_dist;
  logic [OUT_IDX_W-1:0]   res_earlier32;
  logic [OUT_IDX_W-1:0]   res_reuse32;
  logic                   out_free;

  // take no beat while reset is held
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // launch the wavefront into the top cell with the new entry as carry
  always_comb begin
    chain_wave[0].active      = accept;
    chain_wave[0].addr        = in_tdata[ADDR_W-1:0];
    chain_wave[0].carry_valid = 1'b1;
    chain_wave[0].carry_tag   = in_tdata[ADDR_W-1:0];
  end
  assign chain_idx[0] = cnt_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    lsdp_cell #(
      .INDEX_WIDTH(INDEX_WIDTH),
      .IS_LAST    (k == DEPTH - 1)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wave_in    (chain_wave[k]),
      .idx_in     (chain_idx[k]),
      .wave_out   (chain_wave[k+1]),
      .idx_out    (chain_idx[k+1]),
      .status     (cell_status[k]),
      .earlier_idx(cell_earlier[k])
    );
  end

  // only one cell holds the wavefront at a time: OR the outcomes together
  always_comb begin
    res_done    = 1'b0;
    res_hit     = 1'b0;
    res_earlier = '0;
    for (int k = 0; k < DEPTH; k++) begin
      res_done    = res_done | cell_status[k].done;
      res_hit     = res_hit | cell_status[k].hit;
      res_earlier = res_earlier | (cell_status[k].hit ? cell_earlier[k] : '0);
    end
  end

  assign cur_pos     = (state_r == ST_IDLE) ? '0 : pos_r;
  assign cur_now     = (state_r == ST_IDLE) ? cnt_r : now_r;
  assign reuse_full  = cur_now - res_earlier;
  assign dist_ext    = 64'(cur_pos) + 64'd1;
  assign earlier_ext = 64'(res_earlier);
  assign reuse_ext   = 64'(reuse_full);

  // miss reports zeros in every field
  assign res_dist      = res_hit ? dist_ext[DIST_W-1:0] : '0;
  assign res_earlier32 = res_hit ? earlier_ext[OUT_IDX_W-1:0] : '0;
  assign res_reuse32   = res_hit ? reuse_ext[OUT_IDX_W-1:0] : '0;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    now_nxt         = now_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_hit_nxt     = out_hit_r;
    out_dist_nxt    = out_dist_r;
    out_earlier_nxt = out_earlier_r;
    out_reuse_nxt   = out_reuse_r;

    if (accept) begin
      cnt_nxt = cnt_r + 1'b1;
      now_nxt = cnt_r;
    end

    case (state_r)
      ST_IDLE, ST_WALK: begin
        if (accept || state_r == ST_WALK) begin
          if (res_done) begin
            if (out_free) begin
              out_valid_nxt   = 1'b1;
              out_hit_nxt     = res_hit;
              out_dist_nxt    = res_dist;
              out_earlier_nxt = res_earlier32;
              out_reuse_nxt   = res_reuse32;
              state_nxt       = ST_IDLE;
            end else begin
              state_nxt = ST_HOLD;
            end
          end else begin
            pos_nxt   = cur_pos + 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_HOLD: begin
        if (out_tready) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = hold_hit_r;
          out_dist_nxt    = hold_dist_r;
          out_earlier_nxt = hold_earlier_r;
          out_reuse_nxt   = hold_reuse_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    now_r         <= now_nxt;
    out_hit_r     <= out_hit_nxt;
    out_dist_r    <= out_dist_nxt;
    out_earlier_r <= out_earlier_nxt;
    out_reuse_r   <= out_reuse_nxt;
    // park a finished result while the output register is still occupied
    if (res_done && !out_free) begin
      hold_hit_r     <= res_hit;
      hold_dist_r    <= res_dist;
      hold_earlier_r <= res_earlier32;
      hold_reuse_r   <= res_reuse32;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {1'b0, out_reuse_r, out_earlier_r, out_dist_r};

endmodule : lru_stack_distance_profiler_core

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for lru_stack_distance_profiler_core: directed beats, then random
// access streams, every result beat checked against typed values or a behavioral LRU stack kept in the bench.
// Depends on lsdp_pkg and the profiler RTL (lsdp_cell, lru_stack_distance_profiler_core).
`timescale 1ns / 1ps

module tb_top;
  import lsdp_pkg::*;

  localparam int LRU_DEPTH  = 64;
  localparam int SEQ_W      = 32;
  localparam int LINE_TOTAL = 1300;  // stop issuing random beats past this count
  localparam int CALM_AFTER = 1150;  // no idling on either side past this count
  localparam int POOL_N     = 96;    // more lines than the stack holds, so some get evicted

  localparam logic [ADDR_W-1:0] LINE_MAX = {ADDR_W{1'b1}};

  // One result beat as the checker sees it
  typedef struct packed {
    logic                 hit;
    logic [DIST_W-1:0]    stack_dist;
    logic [OUT_IDX_W-1:0] earlier;
    logic [OUT_IDX_W-1:0] reuse;
  } line_report_t;

  typedef struct {
    logic [ADDR_W-1:0] line;
    bit                typed;   // 1: use want below, 0: take the stack model's answer
    line_report_t      want;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  // Behavioral LRU stack: entry 0 is the most recently used line
  logic [ADDR_W-1:0] lru_tag   [LRU_DEPTH];
  bit                lru_live  [LRU_DEPTH];
  logic [SEQ_W-1:0]  lru_stamp [LRU_DEPTH];
  logic [SEQ_W-1:0]  access_seq = '0;

  line_report_t report_q[$];   // results still owed by the block, oldest first
  int           errors      = 0;
  int           lines_sent  = 0;
  bit           calm        = 0;
  int           stall_left  = 0;
  logic [ADDR_W-1:0] pool [POOL_N];

  // Directed beats. Typed rows are trivial to read off: cold lines, back-to-back
  // reuse of the extremes. The rest (deeper hits, one-bit near misses) go to the model.
  dir_row_t dir_rows [0:15] = '{
    '{58'h0,               1'b1, '{1'b0, 7'd0, 32'd0, 32'd0}},  // zero tag, stack empty
    '{58'h0,               1'b1, '{1'b1, 7'd1, 32'd0, 32'd1}},
    '{LINE_MAX,            1'b1, '{1'b0, 7'd0, 32'd0, 32'd0}},
    '{LINE_MAX,            1'b1, '{1'b1, 7'd1, 32'd2, 32'd1}},
    '{58'h0,               1'b1, '{1'b1, 7'd2, 32'd1, 32'd3}},
    '{58'h2AAAAAAAAAAAAAA, 1'b1, '{1'b0, 7'd0, 32'd0, 32'd0}},
    '{58'h155555555555555, 1'b1, '{1'b0, 7'd0, 32'd0, 32'd0}},
    '{58'h200000000000000, 1'b1, '{1'b0, 7'd0, 32'd0, 32'd0}},
    '{58'h1,               1'b1, '{1'b0, 7'd0, 32'd0, 32'd0}},
    '{LINE_MAX,            1'b0, '0},
    '{58'h0,               1'b0, '0},
    '{58'h200000000000000, 1'b0, '0},
    '{58'h100000000000000, 1'b0, '0},  // differs from a live tag in one bit
    '{58'h3,               1'b0, '0},
    '{58'h1,               1'b0, '0},
    '{58'h1,               1'b0, '0}
  };

  lru_stack_distance_profiler_core #(
    .DEPTH       (LRU_DEPTH),
    .INDEX_WIDTH (SEQ_W)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Look a line up in the model stack, move it to the top and return what the
  // block must report. A miss drops the bottom entry when the stack is full.
  function automatic line_report_t lru_touch(input logic [ADDR_W-1:0] line);
    line_report_t r;
    int           pos;
    r   = '0;
    pos = -1;
    for (int k = 0; k < LRU_DEPTH; k++) begin
      if (pos < 0 && lru_live[k] && lru_tag[k] == line) pos = k;
    end
    if (pos >= 0) begin
      r.hit        = 1'b1;
      r.stack_dist = DIST_W'(pos + 1);
      r.earlier    = lru_stamp[pos];
      r.reuse      = access_seq - lru_stamp[pos];
    end else begin
      pos = LRU_DEPTH - 1;
    end
    for (int k = pos; k > 0; k--) begin
      lru_tag[k]   = lru_tag[k-1];
      lru_live[k]  = lru_live[k-1];
      lru_stamp[k] = lru_stamp[k-1];
    end
    lru_tag[0]   = line;
    lru_live[0]  = 1'b1;
    lru_stamp[0] = access_seq;
    access_seq   = access_seq + 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_line();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Offer one beat, optionally after an idle burst, and hold it until accepted.
  // Must be entered right after a rising edge; leaves in_tvalid high.
  task automatic send_line(input logic [ADDR_W-1:0] line, input bit typed,
                           input line_report_t want);
    line_report_t got;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - ADDR_W){1'b0}}, line};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = lru_touch(line);
    report_q.push_back(typed ? want : got);
    lines_sent++;
  endtask

  // Drop valid and hold off until every owed result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (report_q.size() != 0);
  endtask

  // Result side: check each accepted beat, then decide ready for the next cycle.
  always @(posedge clk) begin
    line_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: tuser=%b tdata=%h", $time, out_tuser, out_tdata);
      end else begin
        want = report_q.pop_front();
        if (out_tuser !== want.hit) begin
          errors++;
          $display("%0t: hit mismatch: expected %b, actual %b", $time, want.hit, out_tuser);
        end
        if (out_tdata[6:0] !== want.stack_dist) begin
          errors++;
          $display("%0t: stack_distance mismatch: expected %0d, actual %0d",
                   $time, want.stack_dist, out_tdata[6:0]);
        end
        if (out_tdata[38:7] !== want.earlier) begin
          errors++;
          $display("%0t: earlier_index mismatch: expected %0d, actual %0d",
                   $time, want.earlier, out_tdata[38:7]);
        end
        if (out_tdata[70:39] !== want.reuse) begin
          errors++;
          $display("%0t: reuse_distance mismatch: expected %0d, actual %0d",
                   $time, want.reuse, out_tdata[70:39]);
        end
      end
    end
    // Stall in random bursts; none once the run has gone calm
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    int                sweep_sizes [8];
    int                kind;
    int                span;
    int                passes;
    int                pick;
    logic [ADDR_W-1:0] base;

    sweep_sizes = '{1, 2, 3, 7, 63, 64, 65, 66};
    foreach (lru_live[k]) begin
      lru_live[k]  = 1'b0;
      lru_tag[k]   = '0;
      lru_stamp[k] = '0;
    end
    // Seed the reuse pool with a few structured lines; the rest random
    foreach (pool[k]) pool[k] = rand_line();
    pool[0] = '0;
    pool[1] = LINE_MAX;
    pool[2] = 58'h2AAAAAAAAAAAAAA;
    pool[3] = 58'h155555555555555;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_line(dir_rows[i].line, dir_rows[i].typed, dir_rows[i].want);
    // Let the pipeline empty completely once before the random part
    drain();

    while (lines_sent < LINE_TOTAL) begin
      calm = (lines_sent >= CALM_AFTER);
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        // Cyclic sweep: at the stack size every revisit hits at the bottom,
        // one past it every access misses on an evicted line
        span   = sweep_sizes[$urandom_range(0, 7)];
        passes = $urandom_range(2, 3);
        base   = rand_line();
        for (int p = 0; p < passes; p++)
          for (int j = 0; j < span; j++) send_line(base + ADDR_W'(j), 1'b0, '0);
      end else if (kind <= 6) begin
        // Reuse from the pool, skewed toward low pool indices
        span = $urandom_range(16, 48);
        for (int j = 0; j < span; j++) begin
          pick = $urandom_range(0, $urandom_range(0, POOL_N - 1));
          send_line(pool[pick], 1'b0, '0);
        end
        pool[$urandom_range(4, POOL_N - 1)] = rand_line();
      end else if (kind == 7) begin
        // Noise: fresh lines across the full address width
        span = $urandom_range(1, 8);
        for (int j = 0; j < span; j++) send_line(rand_line(), 1'b0, '0);
      end else if (kind == 8) begin
        // Near misses: a pool line with one bit flipped, then the line itself
        span = $urandom_range(1, 8);
        for (int j = 0; j < span; j++) begin
          pick = $urandom_range(0, POOL_N - 1);
          send_line(pool[pick] ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1)), 1'b0, '0);
          send_line(pool[pick], 1'b0, '0);
        end
      end else begin
        drain();
      end
    end

    // Wait for the tail, then give the chain time to show any stray beat
    drain();
    repeat (2 * LRU_DEPTH + 16) @(posedge clk);
    if (report_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, report_q.size());
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
